// ===== rtl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg
// Shared constants, types and helpers of the integer to radix digits unit.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  // Input value: 33-bit two's complement. Magnitude is held in 32 bits.
  localparam int unsigned IN_BITS    = 33;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_RADIX  = 16;

  // Quotient bits resolved per divider cycle, and divider steps per full division.
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = VALUE_BITS / DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Digit stack: one 4-bit digit per place, radix 2 gives the most places.
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = VALUE_BITS;
  localparam int unsigned COUNT_W    = $clog2(MAX_DIGITS + 1);

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CHAR_W  = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
  localparam logic [63:0]        CHARS_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0]        CHARS_HIGH_RST = 64'h6665646362613938;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR     = 8'h2D;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SIGN   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // Result of one divider cycle.
  typedef struct packed {
    logic [DIV_BITS-1:0] qbits;
    logic [DIGIT_W-1:0]  rem;
  } div_out_t;

  // Character code of digit k from the 16-entry table, digit k in byte k.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [127:0] chars,
                                                   input logic [DIGIT_W-1:0] k);
    logic [6:0] base;
    base = {k, 3'b000};
    return chars[base +: CHAR_W];
  endfunction

endpackage

// ===== rtl/i2rd_divider.sv =====
// ----------------------------------------------------------------------------
// i2rd_divider
// One cycle of restoring division by a small radix: brings in eight dividend
// bits, most significant first, and returns eight quotient bits and the
// running remainder.
// ----------------------------------------------------------------------------
module i2rd_divider (
  input  logic [i2rd_pkg::DIGIT_W-1:0]  rem_in,
  input  logic [i2rd_pkg::DIV_BITS-1:0] chunk,
  input  logic [i2rd_pkg::RADIX_W-1:0]  radix,
  output i2rd_pkg::div_out_t            result
);
  import i2rd_pkg::*;

  logic [DIGIT_W-1:0]  rem [DIV_BITS+1];
  logic [DIV_BITS-1:0] qbits;
  logic [RADIX_W-1:0]  trial [DIV_BITS];

  // Each step shifts one bit into the remainder and subtracts the radix if it
  // fits. The remainder stays below the radix, so four bits hold it.
  always_comb begin
    rem[0] = rem_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial[i] = {rem[i], chunk[DIV_BITS-1-i]};
      if (trial[i] >= radix) begin
        qbits[DIV_BITS-1-i] = 1'b1;
        rem[i+1]            = DIGIT_W'(trial[i] - radix);
      end else begin
        qbits[DIV_BITS-1-i] = 1'b0;
        rem[i+1]            = trial[i][DIGIT_W-1:0];
      end
    end
  end

  assign result.qbits = qbits;
  assign result.rem   = rem[DIV_BITS];

endmodule

// ===== rtl/integer_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts a signed integer to its text in a configurable radix, one
// character per output word, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one 33-bit two's complement value per word. The
//   master channel returns the text one character per word: a leading '-'
//   for negative values, then the digits, with tlast on the final character.
//   Zero gives the single digit for 0. The configuration channel writes the
//   radix (index 0) and the two halves of the digit table (indexes 1 and 2);
//   cfg_ready is always high and writes to other indexes are dropped.
//   A value is divided by the radix repeatedly in a shared divider that
//   resolves eight quotient bits per cycle; each digit takes a full pass over
//   the working value. Digits are pushed on a stack and then popped out one
//   per cycle while the receiver keeps taking them.
//   s_tready is high only while the unit is idle; one item is in flight.
//   The master side has an output register, so a stalled receiver only holds
//   the current character and the unit waits; nothing is dropped.
//   Reset returns the sequencer to idle, empties the output register and
//   restores radix 10 with the table "0123456789abcdef".
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Slave word: [32:0] value, rest zero.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [i2rd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Master word: [7:0] text_char. tlast carries is_last.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [i2rd_pkg::CHAR_W-1:0]       m_tdata,
  output logic                              m_tlast,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [63:0]                       cfg_data
);
  import i2rd_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [63:0]        chars_low;
  logic [63:0]        chars_high;
  logic [RADIX_W-1:0] eff_radix;

  state_t                          state;
  logic [VALUE_BITS-1:0]           work;
  logic [DIGIT_W-1:0]              rem;
  logic [STEP_W-1:0]               step;
  logic [MAX_DIGITS*DIGIT_W-1:0]   stack;
  logic [COUNT_W-1:0]              digit_count;
  logic                            sign_pend;

  logic                            in_fire;
  logic                            out_load;
  logic [IN_BITS-1:0]              in_value;
  logic [IN_BITS-1:0]              neg_value;
  logic [VALUE_BITS-1:0]           in_mag;
  logic [VALUE_BITS-1:0]           work_next;
  div_out_t                        div_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (!m_tvalid || m_tready) && (state == ST_SIGN || state == ST_EMIT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RESET;
      chars_low  <= CHARS_LOW_RST;
      chars_high <= CHARS_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  chars_low  <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the radix into the supported range.
  always_comb begin
    if (radix inside {[5'd0:5'd1]}) begin
      eff_radix = RADIX_W'(2);
    end else if (radix > RADIX_W'(MAX_RADIX)) begin
      eff_radix = RADIX_W'(MAX_RADIX);
    end else begin
      eff_radix = radix;
    end
  end

  // Absolute value of the input; only -2^32 does not fit and saturates.
  assign in_value  = s_tdata[IN_BITS-1:0];
  assign neg_value = IN_BITS'(~in_value + 1'b1);
  always_comb begin
    if (!in_value[IN_BITS-1]) begin
      in_mag = in_value[VALUE_BITS-1:0];
    end else if (neg_value[IN_BITS-1]) begin
      in_mag = '1;
    end else begin
      in_mag = neg_value[VALUE_BITS-1:0];
    end
  end

  // Shared divider, fed from the top byte of the working register.
  i2rd_divider u_div (
    .rem_in (rem),
    .chunk  (work[VALUE_BITS-1 -: DIV_BITS]),
    .radix  (eff_radix),
    .result (div_res)
  );

  // Quotient bits enter at the bottom, so after a full pass work holds it.
  assign work_next = {work[VALUE_BITS-DIV_BITS-1:0], div_res.qbits};

  // Sequencer, digit stack and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      sign_pend   <= 1'b0;
      step        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            work        <= in_mag;
            rem         <= '0;
            step        <= '0;
            digit_count <= '0;
            sign_pend   <= in_value[IN_BITS-1];
            state       <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          work <= work_next;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            // Full division done: the remainder is the next digit up.
            stack       <= {stack[MAX_DIGITS*DIGIT_W-DIGIT_W-1:0], div_res.rem};
            digit_count <= digit_count + 1'b1;
            rem         <= '0;
            if (work_next == '0) begin
              state <= sign_pend ? ST_SIGN : ST_EMIT;
            end
          end else begin
            rem <= div_res.rem;
          end
        end
        ST_SIGN: begin
          if (out_load) begin
            sign_pend <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Pop the most significant digit remaining.
          if (out_load) begin
            stack       <= {{DIGIT_W{1'b0}}, stack[MAX_DIGITS*DIGIT_W-1:DIGIT_W]};
            digit_count <= digit_count - 1'b1;
            if (digit_count == COUNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_SIGN) begin
        m_tdata <= MINUS_CHAR;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= digit_char({chars_high, chars_low}, stack[DIGIT_W-1:0]);
        m_tlast <= (digit_count == COUNT_W'(1));
      end
    end
  end

  // The stack is empty whenever a new value may enter.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> digit_count == '0)
    else $error("digit stack not empty while idle");

  // The stack never holds more digits than a 32-bit magnitude has.
  assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  // An accepted value always starts a division.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_DIVIDE)
    else $error("accepted value did not start a division");

  // The sign is only sent for a negative value and before any digit.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SIGN |-> sign_pend && digit_count != '0)
    else $error("sign state without pending sign or digits");

  // Leaving the emit phase happens only on the word that carries tlast.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_load && digit_count == COUNT_W'(1)) |=> m_tvalid && m_tlast)
    else $error("final character not marked last");

endmodule

// ===== sim/radix_text_checker.sv =====
// ----------------------------------------------------------------------------
// radix_text_checker
// Watches the value, text and configuration channels of the integer to radix
// digits unit. It keeps its own copy of the radix and the digit table, spells
// every accepted value into the characters it must produce, and compares each
// text word taken by the receiver against the oldest character still owed.
// ----------------------------------------------------------------------------
module radix_text_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [i2rd_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [i2rd_pkg::CHAR_W-1:0]     m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [63:0]                     cfg_data,
  output int unsigned                     chars_owed,
  output int unsigned                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2rd_pkg::*;

  // One character of expected text and whether it ends the run.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t         owed_text[$];
  text_char_t         oldest;
  logic [RADIX_W-1:0] base_reg;
  logic [127:0]       char_table;
  int unsigned        fail_count;

  // Spell one value into the queue of owed characters: optional minus sign,
  // then the digits most significant first, the final one marked last.
  function automatic void owe_text(input logic [IN_BITS-1:0] value);
    logic [IN_BITS-1:0] mag_wide;
    logic [31:0]        mag;
    logic [31:0]        base;
    logic [3:0]         digit [0:31];
    int                 count;
    int                 i;
    text_char_t         item;
    // Out-of-range radix settings clamp to the nearest legal base.
    if (base_reg < 2)
      base = 2;
    else if (base_reg > MAX_RADIX)
      base = MAX_RADIX;
    else
      base = base_reg;
    mag_wide = value[IN_BITS-1] ? (~value + 1'b1) : value;
    // Only -2^32 overflows 32 bits; it saturates to the largest magnitude.
    mag = mag_wide[32] ? 32'hFFFF_FFFF : mag_wide[31:0];
    if (value[IN_BITS-1]) begin
      item.code = MINUS_CHAR;
      item.last = 1'b0;
      owed_text.push_back(item);
    end
    count = 0;
    do begin
      digit[count] = 4'(mag % base);
      mag = mag / base;
      count++;
    end while (mag != 0);
    for (i = count - 1; i >= 0; i--) begin
      item.code = char_table[int'(digit[i]) * 8 +: CHAR_W];
      item.last = (i == 0);
      owed_text.push_back(item);
    end
  endfunction

  // Track configuration, predict on every accepted value, check every word.
  always @(posedge clk) begin
    if (rst) begin
      base_reg   = RADIX_RESET;
      char_table = {CHARS_HIGH_RST, CHARS_LOW_RST};
      fail_count = 0;
      owed_text.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIX:      base_reg = cfg_data[RADIX_W-1:0];
          REG_CHARS_LOW:  char_table[63:0] = cfg_data;
          REG_CHARS_HIGH: char_table[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        owe_text(s_tdata[IN_BITS-1:0]);
      if (m_tvalid && m_tready) begin
        if (owed_text.size() == 0) begin
          $error("unexpected word: text_char %h is_last %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          oldest = owed_text.pop_front();
          if (m_tdata !== oldest.code) begin
            $error("text_char mismatch: expected %h, actual %h", oldest.code, m_tdata);
            fail_count++;
          end
          if (m_tlast !== oldest.last) begin
            $error("is_last mismatch: expected %b, actual %b", oldest.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
    chars_owed <= owed_text.size();
    mismatches <= fail_count;
  end

endmodule

// ===== sim/integer_to_radix_digits_unit_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit_tb
// Drives values into the integer to radix digits unit under a series of radix
// and digit table settings: a directed pass over sign, zero, saturation and
// clamped radix cases, then randomized values. The sender works in bursts and
// the receiver stalls in shifting patterns, with long hold-offs that back the
// unit up. A separate checker predicts and compares the text.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2rd_pkg::*;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CHAR_W-1:0]     m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = REG_RADIX;
  logic [63:0]           cfg_data = '0;
  int unsigned           chars_owed;
  int unsigned           mismatches;

  int       eff_base = 10;
  int       burst_left = 0;
  bit       tx_gappy = 1'b1;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold = 0;
  int       rx_taken = 0;
  int       rx_tick = 0;

  integer_to_radix_digits_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  radix_text_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .chars_owed(chars_owed), .mismatches(mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overall time limit for the run.
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall mode changes every so often; two long hold-offs let the
  // unit fill its output register and refuse new values.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rx_taken++;
        if (rx_taken == 150 || rx_taken == 1500)
          rx_hold = 400;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(40, 160);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      if (rx_hold != 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ((rx_tick % 8) < 5);
        endcase
      end
    end
  end

  // Offer one value; between bursts the sender may pause before offering it.
  task automatic send_value(input logic [IN_BITS-1:0] value);
    int gap;
    if (burst_left == 0) begin
      if (tx_gappy) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and let all owed text drain before touching registers.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load radix and table; junk in the upper radix bits and a write to the
  // spare index must both be ignored.
  task automatic program_regs(input logic [4:0] radix, input logic [63:0] low,
                              input logic [63:0] high);
    write_reg(REG_RADIX, {27'($urandom), 32'($urandom), radix});
    write_reg(REG_SPARE, {32'($urandom), 32'($urandom)});
    write_reg(REG_CHARS_LOW, low);
    write_reg(REG_CHARS_HIGH, high);
    cfg_valid <= 1'b0;
    eff_base = (radix < 2) ? 2 : (radix > MAX_RADIX) ? MAX_RADIX : radix;
  endtask

  // Random value: full range, small magnitudes, powers of the base and
  // their neighbors, range extremes, and values of random bit length.
  function automatic logic [IN_BITS-1:0] pick_value();
    logic [IN_BITS-1:0] value;
    logic [63:0]        power;
    int                 steps;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = {1'($urandom_range(0, 1)), 32'($urandom)};
      4: value = IN_BITS'($urandom_range(0, 40));
      5: value = -IN_BITS'($urandom_range(1, 40));
      6: begin
        power = 1;
        steps = $urandom_range(0, 32);
        repeat (steps)
          if (power * eff_base <= 64'hFFFF_FFFF) power = power * eff_base;
        value = IN_BITS'(power + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1) != 0) value = -value;
      end
      7: begin
        case ($urandom_range(0, 5))
          0: value = 33'h0_0000_0000;
          1: value = 33'h0_FFFF_FFFF;
          2: value = 33'h1_0000_0000;
          3: value = 33'h1_0000_0001;
          4: value = 33'h0_8000_0000;
          default: value = 33'h1_8000_0000;
        endcase
      end
      default: begin
        value = IN_BITS'($urandom >> $urandom_range(0, 31));
        if ($urandom_range(0, 1) != 0) value = -value;
      end
    endcase
    return value;
  endfunction

  initial begin
    logic [4:0]  radix;
    logic [63:0] low;
    logic [63:0] high;
    int          phase;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Decimal after reset: zero, signs, saturation of -2^32, range edges.
    send_value(33'h0_0000_0000);
    send_value(33'h0_0000_0001);
    send_value(33'h1_FFFF_FFFF);
    send_value(33'h0_0000_0009);
    send_value(33'h0_0000_000A);
    send_value(33'h0_FFFF_FFFF);
    send_value(33'h1_8000_0000);
    send_value(33'h1_0000_0000);
    send_value(33'h1_0000_0001);
    send_value(33'h0_7FFF_FFFF);
    wait_idle();

    // Binary gives the longest runs; -2^32 yields the full 33 words.
    program_regs(5'd2, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(33'h0_FFFF_FFFF);
    send_value(33'h1_0000_0000);
    send_value(33'h0_0000_0000);
    send_value(33'h1_FFFF_FFFF);
    wait_idle();

    program_regs(5'd16, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(33'h0_FFFF_FFFF);
    send_value(33'h1_8000_0000);
    wait_idle();

    // Radix settings below 2 and above 16 clamp.
    program_regs(5'd0, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(33'h0_0000_0005);
    wait_idle();
    program_regs(5'd1, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(-33'sd6);
    wait_idle();
    program_regs(5'd17, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(33'h0_0000_00FF);
    wait_idle();
    program_regs(5'd31, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_value(33'h0_FEDC_BA98);
    send_value(33'h1_0000_0001);
    wait_idle();

    // Random phases, each with its own radix, table and sender behavior.
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: radix = 5'd2;
        1: radix = 5'd16;
        2: radix = 5'd10;
        3: radix = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 1))
                                               : 5'($urandom_range(17, 31));
        default: radix = 5'($urandom_range(2, 16));
      endcase
      if ($urandom_range(0, 1) != 0) begin
        low  = {32'($urandom), 32'($urandom)};
        high = {32'($urandom), 32'($urandom)};
      end else begin
        low  = CHARS_LOW_RST;
        high = CHARS_HIGH_RST;
      end
      program_regs(radix, low, high);
      tx_gappy = ($urandom_range(0, 3) != 0);
      repeat (31) send_value(pick_value());
      wait_idle();
    end

    // Drain, then allow the unit time to show any stray words.
    s_tvalid <= 1'b0;
    while (chars_owed != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
